// ===== rtl/lvn_pkg.sv =====
// ----------------------------------------------------------------------------
// lvn_pkg
// Shared constants for the lattice value noise core.
// ----------------------------------------------------------------------------
package lvn_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int COORD_W           = 32;
   localparam int NOISE_W           = 17;
   localparam int DIM_W             = 2;
   localparam int CORNERS           = 8;

   localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;
   localparam logic [DIM_W-1:0] DIM_TWO   = 2'd2;
   localparam logic [DIM_W-1:0] DIM_THREE = 2'd3;

   localparam logic [31:0] Y_STRIDE   = 32'd57;
   localparam logic [31:0] Z_STRIDE   = 32'd1337;
   localparam logic [31:0] HASH_MUL   = 32'd15731;
   localparam logic [31:0] HASH_ADD1  = 32'd789221;
   localparam logic [31:0] HASH_ADD2  = 32'd1376312589;
   localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;
   localparam int          HASH_SHIFT = 13;

endpackage

// ===== rtl/lvn_hash.sv =====
// ----------------------------------------------------------------------------
// lvn_hash
// Pipelined integer hash of one lattice id to a corner value, four stages.
// ----------------------------------------------------------------------------
module lvn_hash #(
   parameter int FRAC_BITS = lvn_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [31:0]          id,
   output logic [FRAC_BITS:0]   value
);

   logic [31:0] m_ff, m_in;
   logic [31:0] m2_ff, m_d1_ff;
   logic [31:0] p_ff, m_d2_ff;
   logic [31:0] h_ff;
   logic [31:0] diff;

   assign m_in = (id << lvn_pkg::HASH_SHIFT) ^ id;

   always_ff @(posedge clock) begin
      if (enable) begin
         m_ff    <= m_in;
         m2_ff   <= m_ff * m_ff;
         m_d1_ff <= m_ff;
         p_ff    <= m2_ff * lvn_pkg::HASH_MUL + lvn_pkg::HASH_ADD1;
         m_d2_ff <= m_d1_ff;
         h_ff    <= (m_d2_ff * p_ff + lvn_pkg::HASH_ADD2) & lvn_pkg::HASH_MASK;
      end
   end

   assign diff  = 32'h8000_0000 - h_ff;
   assign value = diff[31 -: (FRAC_BITS+1)];

endmodule

// ===== rtl/lattice_value_noise_core.sv =====
// ----------------------------------------------------------------------------
// lattice_value_noise_core
// Value noise on an integer lattice, one point per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_ beats carry a point (x/y/z, signed fixed point, FRAC_BITS fraction
//   bits). rsp_ beats carry noise_value, unsigned with one integer bit.
//   csr_write_enable loads the dimensions register (1..3, 0 acts as 1);
//   write it only when the core is idle.
//   One beat per cycle is accepted while req_stall is low, through a fully
//   pipelined datapath of eight parallel hash pipes (three 32x32
//   multiplies deep) and three lerp stages.
//   When rsp_stall is high with the output stage full, the whole pipeline
//   holds; req_stall follows rsp_stall only then, so bubbles still drain.
//   Reset (synchronous, active high) empties the pipe and sets dimensions
//   to 3.
// ----------------------------------------------------------------------------
module lattice_value_noise_core #(
   parameter int FRAC_BITS = lvn_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   input  logic signed [31:0] req_z_coord,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_noise_value
);

   localparam int STAGES = 9;
   localparam int VW     = FRAC_BITS + 1;

   logic [1:0] dim_ff;
   logic       advance;
   logic [STAGES-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) dim_ff <= lvn_pkg::DIM_RESET;
      else if (csr_write_enable) dim_ff <= csr_write_data;
   end

   // pipeline holds only if the last stage is full and stalled
   assign advance   = !(vld_ff[STAGES-1] && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[STAGES-2:0], req_valid};
   end

   // stage 0: floor/fraction, base ids
   logic [31:0] cy, cz, ix, iy, iz;
   logic [31:0] base_in [2];
   logic [31:0] base0_ff, base1_ff, base2_ff, base3_ff;
   logic [FRAC_BITS-1:0] tx_ff [STAGES], ty_ff [STAGES], tz_ff [STAGES];

   assign cy = (dim_ff >= lvn_pkg::DIM_TWO)   ? req_y_coord : '0;
   assign cz = (dim_ff >= lvn_pkg::DIM_THREE) ? req_z_coord : '0;
   assign ix = 32'(req_x_coord >>> FRAC_BITS);
   assign iy = 32'($signed(cy) >>> FRAC_BITS);
   assign iz = 32'($signed(cz) >>> FRAC_BITS);

   logic [31:0] yy0, yy1, zz0, zz1;
   assign yy0 = iy * lvn_pkg::Y_STRIDE;
   assign yy1 = yy0 + lvn_pkg::Y_STRIDE;
   assign zz0 = iz * lvn_pkg::Z_STRIDE;
   assign zz1 = zz0 + lvn_pkg::Z_STRIDE;
   assign base_in[0] = ix + yy0;
   assign base_in[1] = ix + yy1;

   always_ff @(posedge clock) begin
      if (advance) begin
         base0_ff <= base_in[0] + zz0;
         base1_ff <= base_in[1] + zz0;
         base2_ff <= base_in[0] + zz1;
         base3_ff <= base_in[1] + zz1;
         tx_ff[0] <= req_x_coord[FRAC_BITS-1:0];
         ty_ff[0] <= cy[FRAC_BITS-1:0];
         tz_ff[0] <= cz[FRAC_BITS-1:0];
         for (int s = 1; s < STAGES; s++) begin
            tx_ff[s] <= tx_ff[s-1];
            ty_ff[s] <= ty_ff[s-1];
            tz_ff[s] <= tz_ff[s-1];
         end
      end
   end

   // stages 1..4: eight hash pipes (corner order z,y,x)
   logic [31:0]   ids [lvn_pkg::CORNERS];
   logic [VW-1:0] cv  [lvn_pkg::CORNERS];
   assign ids[0] = base0_ff;  assign ids[1] = base0_ff + 32'd1;
   assign ids[2] = base1_ff;  assign ids[3] = base1_ff + 32'd1;
   assign ids[4] = base2_ff;  assign ids[5] = base2_ff + 32'd1;
   assign ids[6] = base3_ff;  assign ids[7] = base3_ff + 32'd1;

   for (genvar g = 0; g < lvn_pkg::CORNERS; g++) begin : g_hash
      lvn_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
         .clock(clock), .enable(advance), .id(ids[g]), .value(cv[g])
      );
   end

   function automatic logic [VW-1:0] lerp(input logic [VW-1:0] a,
                                          input logic [VW-1:0] b,
                                          input logic [FRAC_BITS-1:0] t);
      logic [2*VW:0] s;
      logic [VW-1:0] w;
      w = VW'(1 << FRAC_BITS) - VW'(t);
      s = (2*VW+1)'(a * w) + (2*VW+1)'(b * VW'(t));
      return VW'(s >> FRAC_BITS);
   endfunction

   // stages 5..7: blend x, y, z; stage 8 output register
   logic [VW-1:0] rx_ff [4];
   logic [VW-1:0] ry_ff [2];
   logic [VW-1:0] rz_ff;
   logic [16:0]   out_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 4; r++)
            rx_ff[r] <= lerp(cv[2*r], cv[2*r+1], tx_ff[4]);
         for (int r = 0; r < 2; r++)
            ry_ff[r] <= lerp(rx_ff[2*r], rx_ff[2*r+1], ty_ff[5]);
         rz_ff  <= lerp(ry_ff[0], ry_ff[1], tz_ff[6]);
         out_ff <= 17'(rz_ff);
      end
   end

   assign rsp_valid       = vld_ff[STAGES-1];
   assign rsp_noise_value = out_ff;

endmodule

// ===== rtl/lvn_checker.sv =====
// ----------------------------------------------------------------------------
// lvn_checker
// Port-level checks for the lattice value noise core.
// ----------------------------------------------------------------------------
module lvn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_noise_value
);

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_noise_value <= 17'h10000)
      else $error("noise out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("stalled beat changed");

   a_nostall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled without output stall");

   a_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("valid after reset");

endmodule

bind lattice_value_noise_core lvn_checker u_lvn_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_noise_value(rsp_noise_value)
);
